// ===== rtl/tcfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcfr_pkg;

  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned NUM_PULSE = 4;
  localparam int unsigned FLAG_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned MIN_PAYLOAD = 4;

  // result status codes
  localparam logic [1:0] ST_SUCCESS   = 2'd0;
  localparam logic [1:0] ST_FRAME_ERR = 2'd1;
  localparam logic [1:0] ST_CMD_ERR   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT   = 2'd3;

  // frame kinds
  localparam logic [1:0] KIND_THR = 2'd0;
  localparam logic [1:0] KIND_CMD = 2'd1;
  localparam logic [1:0] KIND_BAT = 2'd2;

  // error flag bit positions
  localparam int unsigned FLAG_CHECKSUM  = 0;
  localparam int unsigned FLAG_NO_DEVICE = 1;
  localparam int unsigned FLAG_ODD_DATA  = 2;
  localparam int unsigned FLAG_BAD_PULSE = 3;
  localparam int unsigned FLAG_WIDTH     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_MASK   = 3'd5;

  // framing bytes
  localparam logic [7:0] BYTE_T    = 8'h54;
  localparam logic [7:0] BYTE_C    = 8'h43;
  localparam logic [7:0] BYTE_E    = 8'h45;
  localparam logic [7:0] BYTE_MARK = 8'hFF;
  localparam logic [7:0] DEV_LOW   = 8'hF0;
  localparam logic [7:0] DEV_HIGH  = 8'hFE;
  localparam logic [7:0] CMD_MAX   = 8'h0F;
  localparam logic [PULSE_W-1:0] NEUTRAL_PULSE = 16'd1500;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_THR  = 4'b0010,
    MODE_CMD  = 4'b0100,
    MODE_BAT  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_low;
    logic [PULSE_W-1:0] pulse_high;
    logic [PULSE_W-1:0] dead_low;
    logic [PULSE_W-1:0] dead_high;
    logic [15:0]        timeout;
    logic [3:0]         cap_mask;
  } tcfr_cfg_t;

  // what the deframer hands to the checker for one item
  typedef struct packed {
    logic                              produce;
    logic [1:0]                        status;
    logic [1:0]                        kind;
    logic                              thr;
    logic                              cs_bad;
    logic [7:0]                        device;
    logic [LEN_W-1:0]                  length;
    logic [NUM_PULSE-1:0][PULSE_W-1:0] pulse;
    logic [2:0]                        pairs;
    logic                              odd;
    logic [7:0]                        cmd_value;
    logic [15:0]                       bat_value;
  } tcfr_event_t;

  typedef struct packed {
    logic [1:0]                        status;
    logic [1:0]                        kind;
    logic [FLAG_W-1:0]                 flags;
    logic [7:0]                        device;
    logic [LEN_W-1:0]                  length;
    logic [NUM_PULSE-1:0]              select;
    logic [NUM_PULSE-1:0][PULSE_W-1:0] pulse;
    logic [7:0]                        cmd_value;
    logic [15:0]                       bat_value;
  } tcfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/tcfr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcfr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcfr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  frame_kind;
  logic [4:0]  error_flags;
  logic [7:0]  device_code;
  logic [3:0]  payload_length;
  logic [3:0]  thruster_select;
  logic [15:0] pulse_main_left;
  logic [15:0] pulse_main_right;
  logic [15:0] pulse_side_left;
  logic [15:0] pulse_side_right;
  logic [7:0]  command_value;
  logic [15:0] battery_value;

  modport source (
    output valid, input ready,
    output status, output frame_kind, output error_flags, output device_code,
    output payload_length, output thruster_select,
    output pulse_main_left, output pulse_main_right,
    output pulse_side_left, output pulse_side_right,
    output command_value, output battery_value
  );
  modport sink (
    input valid, output ready,
    input status, input frame_kind, input error_flags, input device_code,
    input payload_length, input thruster_select,
    input pulse_main_left, input pulse_main_right,
    input pulse_side_left, input pulse_side_right,
    input command_value, input battery_value
  );
endinterface

`default_nettype wire

// ===== rtl/tcfr_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcfr_deframer
  import tcfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  logic        item_fire_i,
  input  logic        item_opcode_i,
  input  logic [7:0]  item_byte_i,
  input  tcfr_cfg_t   cfg_i,
  output tcfr_event_t event_o
);

  localparam int unsigned DEPTH = MAX_PAYLOAD + 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned PAD   = 2 * NUM_PULSE + 1;

  mode_e       mode_q, mode_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        armed_q, armed_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  cs_q, cs_d;
  logic        we;
  logic [7:0]  store_q [DEPTH];
  logic [7:0]  store_pad [PAD];

  logic [CW-1:0] len;
  logic [CW-1:0] datalen;
  logic [15:0]   tick_inc;
  logic [7:0]    d0, d1, d2;

  for (genvar i = 0; i < PAD; i++) begin : g_pad
    if (i < DEPTH) begin : g_in
      assign store_pad[i] = store_q[i];
    end else begin : g_out
      assign store_pad[i] = '0;
    end
  end

  assign len      = cnt_q - CW'(1);
  assign datalen  = len - CW'(2);
  assign tick_inc = (tick_q != TICK_MAX) ? tick_q + 16'd1 : tick_q;
  assign d0       = store_q[0];
  assign d1       = store_q[1];
  assign d2       = store_q[2];

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    armed_d = armed_q;
    tick_d  = tick_q;
    cs_d    = cs_q;
    we      = 1'b0;
    event_o = '0;
    if (item_valid_i) begin
      if (item_opcode_i) begin
        if (mode_q != MODE_IDLE) begin
          tick_d = tick_inc;
          if (tick_inc > cfg_i.timeout) begin
            event_o.produce = 1'b1;
            event_o.status  = ST_TIMEOUT;
            case (mode_q)
              MODE_CMD: event_o.kind = KIND_CMD;
              MODE_BAT: event_o.kind = KIND_BAT;
              default:  event_o.kind = KIND_THR;
            endcase
            mode_d  = MODE_IDLE;
            cnt_d   = '0;
            armed_d = 1'b0;
          end
        end
      end else begin
        case (mode_q)
          MODE_THR: begin
            if (armed_q && item_byte_i == BYTE_E) begin
              event_o.produce = 1'b1;
              event_o.kind    = KIND_THR;
              event_o.length  = LEN_W'(len);
              if (len < CW'(MIN_PAYLOAD)) begin
                event_o.status = ST_FRAME_ERR;
              end else begin
                event_o.status = ST_SUCCESS;
                event_o.thr    = 1'b1;
                // running xor includes the final end mark
                event_o.cs_bad = (cs_q != BYTE_MARK);
                event_o.device = store_q[0];
                event_o.pairs  = 3'(datalen >> 1);
                event_o.odd    = datalen[0];
                for (int k = 0; k < NUM_PULSE; k++) begin
                  event_o.pulse[k] = {store_pad[2 * k + 2], store_pad[2 * k + 1]};
                end
              end
              mode_d  = MODE_IDLE;
              cnt_d   = '0;
              armed_d = 1'b0;
            end else if ((armed_q && item_byte_i != BYTE_MARK) || cnt_q >= CW'(DEPTH)) begin
              event_o.produce = 1'b1;
              event_o.status  = ST_FRAME_ERR;
              event_o.kind    = KIND_THR;
              mode_d  = MODE_IDLE;
              cnt_d   = '0;
              armed_d = 1'b0;
            end else begin
              we      = 1'b1;
              cnt_d   = cnt_q + CW'(1);
              armed_d = (item_byte_i == BYTE_MARK);
              cs_d    = cs_q ^ item_byte_i;
            end
          end
          MODE_CMD: begin
            if (cnt_q < CW'(2)) begin
              if (item_byte_i == BYTE_E) begin
                event_o.produce = 1'b1;
                event_o.status  = ST_CMD_ERR;
                event_o.kind    = KIND_CMD;
                mode_d  = MODE_IDLE;
                cnt_d   = '0;
                armed_d = 1'b0;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
            end else begin
              event_o.produce = 1'b1;
              event_o.kind    = KIND_CMD;
              event_o.status  = ST_CMD_ERR;
              mode_d  = MODE_IDLE;
              cnt_d   = '0;
              armed_d = 1'b0;
              if (item_byte_i == BYTE_E) begin
                event_o.cmd_value = d0;
                if (d0 != d1 || d0 > CMD_MAX || d0 == 8'd0) begin
                  event_o.status = ST_CMD_ERR;
                end else begin
                  event_o.status = ST_SUCCESS;
                  // tick count keeps running into the battery frame
                  if ((d0[3:0] & cfg_i.cap_mask) == cfg_i.cap_mask) begin
                    mode_d = MODE_BAT;
                  end
                end
              end
            end
          end
          MODE_BAT: begin
            if (cnt_q < CW'(3)) begin
              we    = 1'b1;
              cnt_d = cnt_q + CW'(1);
            end else begin
              event_o.produce   = 1'b1;
              event_o.kind      = KIND_BAT;
              event_o.bat_value = {d1, d0};
              if (item_byte_i != BYTE_E) begin
                event_o.status = ST_FRAME_ERR;
              end else if ((d0 ^ d1 ^ d2) != 8'd0) begin
                event_o.status = ST_CMD_ERR;
              end else begin
                event_o.status = ST_SUCCESS;
              end
              mode_d  = MODE_IDLE;
              cnt_d   = '0;
              armed_d = 1'b0;
            end
          end
          default: begin
            if (item_byte_i == BYTE_T || item_byte_i == BYTE_C) begin
              mode_d  = (item_byte_i == BYTE_T) ? MODE_THR : MODE_CMD;
              cnt_d   = '0;
              armed_d = 1'b0;
              tick_d  = '0;
              cs_d    = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      cnt_q   <= '0;
      armed_q <= 1'b0;
      tick_q  <= '0;
      cs_q    <= '0;
    end else if (item_fire_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      tick_q  <= tick_d;
      cs_q    <= cs_d;
    end
  end

  // frame bytes, no reset
  always_ff @(posedge clk_i) begin
    if (item_fire_i && we) begin
      store_q[cnt_q[IW-1:0]] <= item_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcfr_checker
  import tcfr_pkg::*;
#(
  parameter int unsigned THRUSTER_COUNT = 4
) (
  input  tcfr_event_t  event_i,
  input  tcfr_cfg_t    cfg_i,
  output tcfr_result_t result_o
);

  logic [NUM_PULSE-1:0]              sel;
  logic [2:0]                        nsel;
  logic                              limit_bad;
  logic [NUM_PULSE-1:0][PULSE_W-1:0] pd;
  logic [NUM_PULSE-1:0][PULSE_W-1:0] route;
  logic [2:0]                        idx;

  always_comb begin
    for (int b = 0; b < NUM_PULSE; b++) begin
      sel[b] = (b < THRUSTER_COUNT) && !event_i.device[b];
    end
    nsel = 3'($countones(sel));

    limit_bad = 1'b0;
    for (int k = 0; k < NUM_PULSE; k++) begin
      if (3'(k) < event_i.pairs &&
          (event_i.pulse[k] > cfg_i.pulse_high || event_i.pulse[k] < cfg_i.pulse_low)) begin
        limit_bad = 1'b1;
      end
      pd[k] = (event_i.pulse[k] >= cfg_i.dead_low && event_i.pulse[k] <= cfg_i.dead_high)
              ? NEUTRAL_PULSE : event_i.pulse[k];
    end

    // pulses go in order to the selected thrusters
    route = '0;
    idx   = '0;
    for (int b = 0; b < NUM_PULSE; b++) begin
      if (sel[b]) begin
        if (idx < event_i.pairs) begin
          route[b] = pd[idx[1:0]];
        end
        idx = idx + 3'd1;
      end
    end

    result_o           = '0;
    result_o.status    = event_i.status;
    result_o.kind      = event_i.kind;
    result_o.length    = event_i.length;
    result_o.cmd_value = event_i.cmd_value;
    result_o.bat_value = event_i.bat_value;
    if (event_i.thr) begin
      result_o.flags[FLAG_CHECKSUM]  = event_i.cs_bad;
      result_o.flags[FLAG_NO_DEVICE] = (event_i.device < DEV_LOW) ||
                                       (event_i.device > DEV_HIGH);
      result_o.flags[FLAG_ODD_DATA]  = event_i.odd;
      result_o.flags[FLAG_WIDTH]     = !event_i.odd && (event_i.pairs != nsel);
      result_o.flags[FLAG_BAD_PULSE] = !event_i.odd && (event_i.pairs == nsel) && limit_bad;
      result_o.device = event_i.device;
      result_o.select = sel;
      result_o.pulse  = route;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/thruster_command_frame_receiver.sv =====
// a result passes from the input register through deframer and checker into the result register
// throughput: one request per cycle when not stalled; input register, deframer and checker, result register
// the input side stalls only while a finished result waits at the output
// reset (async, active low): idle, counters clear, config registers at their defaults
// frame byte store and the input and result data registers are not reset; the store is filled as bytes arrive
`timescale 1ns / 1ps
`default_nettype none

module thruster_command_frame_receiver
  import tcfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD    = 10,
  parameter int unsigned THRUSTER_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tcfr_in_if.sink              in_i,
  tcfr_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  tcfr_cfg_t    cfg_q;
  logic         inq_valid_q;
  logic         inq_op_q;
  logic [7:0]   inq_byte_q;
  logic         outq_valid_q;
  tcfr_result_t outq_q;
  tcfr_event_t  ev;
  tcfr_result_t res;
  logic         proc_fire;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_low  <= 16'd1100;
      cfg_q.pulse_high <= 16'd1900;
      cfg_q.dead_low   <= 16'd1475;
      cfg_q.dead_high  <= 16'd1525;
      cfg_q.timeout    <= 16'd100;
      cfg_q.cap_mask   <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PULSE_LOW:  cfg_q.pulse_low  <= cfg_data_i;
        CFG_PULSE_HIGH: cfg_q.pulse_high <= cfg_data_i;
        CFG_DEAD_LOW:   cfg_q.dead_low   <= cfg_data_i;
        CFG_DEAD_HIGH:  cfg_q.dead_high  <= cfg_data_i;
        CFG_TIMEOUT:    cfg_q.timeout    <= cfg_data_i;
        CFG_CAP_MASK:   cfg_q.cap_mask   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // held item moves on unless its result would overwrite a waiting one
  assign proc_fire  = inq_valid_q && (!ev.produce || !outq_valid_q || out_o.ready);
  assign in_i.ready = !inq_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      inq_valid_q <= 1'b1;
    end else if (proc_fire) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      inq_op_q   <= in_i.opcode;
      inq_byte_q <= in_i.rx_byte;
    end
  end

  tcfr_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (inq_valid_q),
    .item_fire_i  (proc_fire),
    .item_opcode_i(inq_op_q),
    .item_byte_i  (inq_byte_q),
    .cfg_i        (cfg_q),
    .event_o      (ev)
  );

  tcfr_checker #(
    .THRUSTER_COUNT(THRUSTER_COUNT)
  ) u_checker (
    .event_i (ev),
    .cfg_i   (cfg_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outq_valid_q <= 1'b0;
    end else if (proc_fire && ev.produce) begin
      outq_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      outq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && ev.produce) begin
      outq_q <= res;
    end
  end

  assign out_o.valid            = outq_valid_q;
  assign out_o.status           = outq_q.status;
  assign out_o.frame_kind       = outq_q.kind;
  assign out_o.error_flags      = outq_q.flags;
  assign out_o.device_code      = outq_q.device;
  assign out_o.payload_length   = outq_q.length;
  assign out_o.thruster_select  = outq_q.select;
  assign out_o.pulse_main_left  = outq_q.pulse[0];
  assign out_o.pulse_main_right = outq_q.pulse[1];
  assign out_o.pulse_side_left  = outq_q.pulse[2];
  assign out_o.pulse_side_right = outq_q.pulse[3];
  assign out_o.command_value    = outq_q.cmd_value;
  assign out_o.battery_value    = outq_q.bat_value;

  // a new result only comes from an item held in the input register
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(outq_valid_q) |-> $past(inq_valid_q))
    else $error("result appeared without a held item");

  // thruster detail only on successful results
  a_detail_on_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_SUCCESS) |->
      (out_o.thruster_select == '0 && out_o.error_flags == '0))
    else $error("thruster detail on a failed result");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload_length <= LEN_W'(MAX_PAYLOAD) &&
                     out_o.frame_kind != 2'd3))
    else $error("result length or kind out of range");

endmodule

`default_nettype wire

// ===== sim/thruster_command_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

module thruster_command_frame_receiver_tb;
  import tcfr_pkg::*;

  localparam int unsigned PAYLOAD_MAX = 10;
  localparam int unsigned THR_COUNT   = 4;
  localparam int unsigned STORE_SIZE  = PAYLOAD_MAX + 1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct {
    logic         op;
    logic [7:0]   b;
    bit           typed;
    tcfr_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  tcfr_in_if  in_if ();
  tcfr_out_if out_if ();

  thruster_command_frame_receiver #(
    .MAX_PAYLOAD   (PAYLOAD_MAX),
    .THRUSTER_COUNT(THR_COUNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the deframer
  tcfr_cfg_t   regs;
  mode_e       rx_mode;
  int          rx_count;
  logic [7:0]  rx_store [STORE_SIZE];
  bit          rx_armed;
  logic [15:0] rx_ticks;

  tcfr_result_t expected_frames [$];
  int errors     = 0;
  int sent_items = 0;
  int burst_left = 0;
  bit no_gaps    = 1'b0;

  function automatic void frame_idle();
    rx_mode  = MODE_IDLE;
    rx_count = 0;
    rx_armed = 1'b0;
  endfunction

  // one request into the shadow; returns 1 when the request closes a frame
  function automatic bit deframe(input logic op, input logic [7:0] b,
                                 output tcfr_result_t r);
    int plen, dlen, pairs, nsel, idx;
    logic [7:0] dev, sum, d0, d1, cs;
    logic [FLAG_W-1:0] flags;
    logic [15:0] pw [NUM_PULSE];
    r = '0;
    if (op == OP_TICK) begin
      if (rx_mode == MODE_IDLE) return 1'b0;
      if (rx_ticks != TICK_MAX) rx_ticks++;
      if (rx_ticks > regs.timeout) begin
        r.status = ST_TIMEOUT;
        r.kind = (rx_mode == MODE_CMD) ? KIND_CMD : (rx_mode == MODE_BAT) ? KIND_BAT : KIND_THR;
        frame_idle();
        return 1'b1;
      end
      return 1'b0;
    end
    case (rx_mode)
      MODE_THR: begin
        r.kind = KIND_THR;
        if (rx_armed && b == BYTE_E) begin
          plen = rx_count - 1;
          frame_idle();
          if (plen < MIN_PAYLOAD) begin
            r.status = ST_FRAME_ERR;
            r.length = plen[3:0];
            return 1'b1;
          end
          dev = rx_store[0];
          sum = '0;
          flags = '0;
          for (int i = 0; i < plen; i++) sum ^= rx_store[i];
          if (sum != 8'h00) flags[FLAG_CHECKSUM] = 1'b1;
          if (dev < DEV_LOW || dev > DEV_HIGH) flags[FLAG_NO_DEVICE] = 1'b1;
          dlen = plen - 2;
          pairs = dlen / 2;
          nsel = 0;
          for (int t = 0; t < THR_COUNT; t++) begin
            if (!dev[t]) begin
              r.select[t] = 1'b1;
              nsel++;
            end
          end
          for (int k = 0; k < pairs; k++) pw[k] = {rx_store[2*k+2], rx_store[2*k+1]};
          if (dlen % 2 != 0) begin
            flags[FLAG_ODD_DATA] = 1'b1;
          end else if (pairs != nsel) begin
            flags[FLAG_WIDTH] = 1'b1;
          end else begin
            for (int k = 0; k < pairs; k++) begin
              if (pw[k] > regs.pulse_high || pw[k] < regs.pulse_low) flags[FLAG_BAD_PULSE] = 1'b1;
            end
          end
          // pulse pairs go in order to the selected thrusters
          idx = 0;
          for (int t = 0; t < NUM_PULSE; t++) begin
            if (r.select[t]) begin
              if (idx < pairs) begin
                if (pw[idx] >= regs.dead_low && pw[idx] <= regs.dead_high) begin
                  r.pulse[t] = NEUTRAL_PULSE;
                end else begin
                  r.pulse[t] = pw[idx];
                end
              end
              idx++;
            end
          end
          r.status = ST_SUCCESS;
          r.flags  = flags;
          r.device = dev;
          r.length = plen[3:0];
          return 1'b1;
        end
        if ((rx_armed && b != BYTE_MARK) || rx_count >= STORE_SIZE) begin
          r.status = ST_FRAME_ERR;
          frame_idle();
          return 1'b1;
        end
        rx_store[rx_count] = b;
        rx_count++;
        rx_armed = (b == BYTE_MARK);
        return 1'b0;
      end
      MODE_CMD: begin
        r.kind = KIND_CMD;
        if (rx_count < 2) begin
          if (b == BYTE_E) begin
            r.status = ST_CMD_ERR;
            frame_idle();
            return 1'b1;
          end
          rx_store[rx_count] = b;
          rx_count++;
          return 1'b0;
        end
        frame_idle();
        if (b != BYTE_E) begin
          r.status = ST_CMD_ERR;
          return 1'b1;
        end
        d0 = rx_store[0];
        d1 = rx_store[1];
        if (d0 != d1 || d0 > CMD_MAX || d0 == 8'h00) begin
          r.status = ST_CMD_ERR;
        end else begin
          r.status = ST_SUCCESS;
          // tick count keeps running into the battery frame
          if ((d0[3:0] & regs.cap_mask) == regs.cap_mask) rx_mode = MODE_BAT;
        end
        r.cmd_value = d0;
        return 1'b1;
      end
      MODE_BAT: begin
        r.kind = KIND_BAT;
        if (rx_count < 3) begin
          rx_store[rx_count] = b;
          rx_count++;
          return 1'b0;
        end
        d0 = rx_store[0];
        d1 = rx_store[1];
        cs = rx_store[2];
        frame_idle();
        if (b != BYTE_E) r.status = ST_FRAME_ERR;
        else if ((d0 ^ d1 ^ cs) != 8'h00) r.status = ST_CMD_ERR;
        else r.status = ST_SUCCESS;
        r.bat_value = {d1, d0};
        return 1'b1;
      end
      default: begin
        if (b == BYTE_T || b == BYTE_C) begin
          frame_idle();
          rx_mode  = (b == BYTE_T) ? MODE_THR : MODE_CMD;
          rx_ticks = '0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic tcfr_result_t mk_result(input logic [1:0] st, input logic [1:0] kd,
                                             input logic [3:0] ln, input logic [7:0] cv,
                                             input logic [15:0] bv);
    tcfr_result_t r;
    r = '0;
    r.status    = st;
    r.kind      = kd;
    r.length    = ln;
    r.cmd_value = cv;
    r.bat_value = bv;
    return r;
  endfunction

  function automatic stim_row_t plain(input logic op, input logic [7:0] b);
    stim_row_t row;
    row.op    = op;
    row.b     = b;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic stim_row_t ends(input logic [7:0] b, input tcfr_result_t w);
    stim_row_t row;
    row.op    = OP_BYTE;
    row.b     = b;
    row.typed = 1'b1;
    row.want  = w;
    return row;
  endfunction

  task automatic push_req(input logic op, input logic [7:0] b, input bit typed = 1'b0,
                          input tcfr_result_t want = '0);
    tcfr_result_t r;
    bit closes;
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.opcode  <= op;
    in_if.rx_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_items++;
    closes = deframe(op, b, r);
    if (typed) expected_frames.push_back(want);
    else if (closes) expected_frames.push_back(r);
  endtask

  // frame byte, now and then preceded by a timer tick
  task automatic frame_byte(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0) push_req(OP_TICK, 8'($urandom));
    push_req(OP_BYTE, b);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic close_frame();
    while (rx_mode != MODE_IDLE) push_req(OP_BYTE, 8'h00);
  endtask

  task automatic load_regs(input tcfr_cfg_t c);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_DAT_W-1:0] val [6];
    idx = '{CFG_PULSE_LOW, CFG_PULSE_HIGH, CFG_DEAD_LOW, CFG_DEAD_HIGH, CFG_TIMEOUT,
            CFG_CAP_MASK};
    val = '{c.pulse_low, c.pulse_high, c.dead_low, c.dead_high, c.timeout,
            {12'd0, c.cap_mask}};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    regs = c;
  endtask

  task automatic random_phase(input int quota);
    int stop_at, pick, nsel, npairs, nbytes;
    logic [7:0] dev, cs, v, b0, b1;
    logic [15:0] p;
    logic [7:0] body [$];
    stop_at = sent_items + quota;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 39);
      if (pick < 20) begin
        // thruster frame, mostly well formed
        dev = ($urandom_range(0, 9) < 7) ? {4'hF, 4'($urandom)} : 8'($urandom);
        nsel = 0;
        for (int t = 0; t < THR_COUNT; t++) if (!dev[t]) nsel++;
        npairs = ($urandom_range(0, 9) < 7) ? nsel : $urandom_range(0, 4);
        body = {};
        body.push_back(dev);
        for (int k = 0; k < npairs; k++) begin
          case ($urandom_range(0, 7))
            0: p = regs.pulse_low + 16'($urandom_range(0, 2)) - 16'd1;
            1: p = regs.pulse_high + 16'($urandom_range(0, 2)) - 16'd1;
            2: p = regs.dead_low + 16'($urandom_range(0, 2)) - 16'd1;
            3: p = regs.dead_high + 16'($urandom_range(0, 2)) - 16'd1;
            4: p = NEUTRAL_PULSE;
            5: p = 16'($urandom);
            default: p = 16'($urandom_range(1000, 2000));
          endcase
          body.push_back(p[7:0]);
          body.push_back(p[15:8]);
        end
        if ($urandom_range(0, 6) == 0) body.push_back(8'($urandom));
        cs = '0;
        foreach (body[i]) cs ^= body[i];
        if ($urandom_range(0, 6) == 0) cs = 8'($urandom);
        body.push_back(cs);
        push_req(OP_BYTE, BYTE_T);
        foreach (body[i]) begin
          if ($urandom_range(0, 59) == 0) begin
            repeat ($urandom_range(1, 16)) push_req(OP_TICK, 8'($urandom));
          end
          frame_byte(body[i]);
        end
        frame_byte(BYTE_MARK);
        if ($urandom_range(0, 9) == 0) frame_byte(BYTE_MARK);
        frame_byte(BYTE_E);
      end else if (pick < 31) begin
        // command frame, battery frame when it opens one
        v  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 15)) : 8'($urandom);
        b1 = ($urandom_range(0, 6) != 0) ? v : 8'($urandom);
        push_req(OP_BYTE, BYTE_C);
        if ($urandom_range(0, 19) == 0) begin
          frame_byte(BYTE_E);
        end else begin
          frame_byte(v);
          frame_byte(b1);
          frame_byte(($urandom_range(0, 9) != 0) ? BYTE_E : 8'($urandom));
        end
        if (rx_mode == MODE_BAT) begin
          b0 = 8'($urandom);
          b1 = 8'($urandom);
          cs = ($urandom_range(0, 6) != 0) ? (b0 ^ b1) : 8'($urandom);
          if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 16)) push_req(OP_TICK, 8'($urandom));
          end
          frame_byte(b0);
          frame_byte(b1);
          frame_byte(cs);
          frame_byte(($urandom_range(0, 9) != 0) ? BYTE_E : 8'($urandom));
        end
      end else if (pick < 34) begin
        // line noise: bytes and ticks
        repeat ($urandom_range(1, 6)) push_req(1'($urandom), 8'($urandom));
      end else if (pick < 36) begin
        // short payload
        push_req(OP_BYTE, BYTE_T);
        repeat ($urandom_range(0, 2)) frame_byte(8'($urandom_range(0, 254)));
        frame_byte(BYTE_MARK);
        frame_byte(BYTE_E);
      end else if (pick < 38) begin
        // unterminated or overlong thruster frame
        push_req(OP_BYTE, BYTE_T);
        nbytes = $urandom_range(1, 14);
        repeat (nbytes) frame_byte(($urandom_range(0, 7) == 0) ? BYTE_MARK : 8'($urandom));
        frame_byte(BYTE_MARK);
        frame_byte(BYTE_E);
      end else if (pick == 38) begin
        drain();
      end else begin
        push_req(OP_BYTE, BYTE_T);
        repeat ($urandom_range(1, 30)) push_req(OP_TICK, 8'($urandom));
      end
    end
    close_frame();
    drain();
  endtask

  // result side stalls on a rotating pattern that is redrawn now and then
  logic [7:0] stall_pat;
  int pat_age = 0;
  always @(negedge clk_i) begin
    if (pat_age == 0) begin
      stall_pat     <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      pat_age       <= $urandom_range(50, 300);
      out_if.ready  <= 1'b1;
    end else begin
      stall_pat     <= {stall_pat[6:0], stall_pat[7]};
      pat_age       <= pat_age - 1;
      out_if.ready  <= stall_pat[0];
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    tcfr_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_frames.size() == 0) begin
        $error("result with no frame pending: status %0d kind %0d", out_if.status,
               out_if.frame_kind);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        check_field("status", want.status, out_if.status);
        check_field("frame_kind", want.kind, out_if.frame_kind);
        check_field("error_flags", want.flags, out_if.error_flags);
        check_field("device_code", want.device, out_if.device_code);
        check_field("payload_length", want.length, out_if.payload_length);
        check_field("thruster_select", want.select, out_if.thruster_select);
        check_field("pulse_main_left", want.pulse[0], out_if.pulse_main_left);
        check_field("pulse_main_right", want.pulse[1], out_if.pulse_main_right);
        check_field("pulse_side_left", want.pulse[2], out_if.pulse_side_left);
        check_field("pulse_side_right", want.pulse[3], out_if.pulse_side_right);
        check_field("command_value", want.cmd_value, out_if.command_value);
        check_field("battery_value", want.bat_value, out_if.battery_value);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    tcfr_cfg_t cfg;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.opcode  = OP_BYTE;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    regs.pulse_low  = 16'd1100;
    regs.pulse_high = 16'd1900;
    regs.dead_low   = 16'd1475;
    regs.dead_high  = 16'd1525;
    regs.timeout    = 16'd100;
    regs.cap_mask   = 4'd8;
    frame_idle();
    rx_ticks = '0;
    foreach (rx_store[i]) rx_store[i] = 8'h00;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    rows = '{
      plain(OP_BYTE, 8'h00),
      plain(OP_TICK, 8'hFF),
      // end mark straight after the start byte
      plain(OP_BYTE, BYTE_T), plain(OP_BYTE, BYTE_MARK),
      ends(BYTE_E, mk_result(ST_FRAME_ERR, KIND_THR, 4'd0, 8'h00, 16'h0000)),
      plain(OP_BYTE, BYTE_C),
      ends(BYTE_E, mk_result(ST_CMD_ERR, KIND_CMD, 4'd0, 8'h00, 16'h0000)),
      plain(OP_BYTE, BYTE_C), plain(OP_BYTE, 8'hFF), plain(OP_BYTE, 8'hFF),
      ends(BYTE_E, mk_result(ST_CMD_ERR, KIND_CMD, 4'd0, 8'hFF, 16'h0000)),
      // all command bits set opens a battery frame
      plain(OP_BYTE, BYTE_C), plain(OP_BYTE, CMD_MAX), plain(OP_BYTE, CMD_MAX),
      ends(BYTE_E, mk_result(ST_SUCCESS, KIND_CMD, 4'd0, CMD_MAX, 16'h0000)),
      plain(OP_BYTE, 8'hFF), plain(OP_BYTE, 8'h00), plain(OP_BYTE, 8'hFF),
      ends(BYTE_E, mk_result(ST_SUCCESS, KIND_BAT, 4'd0, 8'h00, 16'h00FF)),
      // longest payload, four neutral pulses
      plain(OP_BYTE, BYTE_T), plain(OP_BYTE, 8'hF0),
      plain(OP_BYTE, 8'hDC), plain(OP_BYTE, 8'h05), plain(OP_BYTE, 8'hDC), plain(OP_BYTE, 8'h05),
      plain(OP_BYTE, 8'hDC), plain(OP_BYTE, 8'h05), plain(OP_BYTE, 8'hDC), plain(OP_BYTE, 8'h05),
      plain(OP_BYTE, 8'hF0), plain(OP_BYTE, BYTE_MARK), plain(OP_BYTE, BYTE_E)
    };
    foreach (rows[i]) push_req(rows[i].op, rows[i].b, rows[i].typed, rows[i].want);
    drain();

    random_phase(320);

    cfg.pulse_low  = 16'h0000;
    cfg.pulse_high = 16'hFFFF;
    cfg.dead_low   = 16'h0000;
    cfg.dead_high  = 16'h0000;
    cfg.timeout    = 16'd3;
    cfg.cap_mask   = 4'h0;
    load_regs(cfg);
    random_phase(260);

    // nothing passes the limits, first tick in a frame times out
    cfg.pulse_low  = 16'hFFFF;
    cfg.pulse_high = 16'h0000;
    cfg.dead_low   = 16'hFFFF;
    cfg.dead_high  = 16'hFFFF;
    cfg.timeout    = 16'd0;
    cfg.cap_mask   = 4'hF;
    load_regs(cfg);
    random_phase(200);

    cfg.pulse_low  = 16'($urandom_range(800, 1500));
    cfg.pulse_high = 16'($urandom_range(1500, 2200));
    cfg.dead_low   = 16'($urandom_range(1400, 1550));
    cfg.dead_high  = 16'($urandom_range(1450, 1600));
    cfg.timeout    = 16'($urandom_range(1, 12));
    cfg.cap_mask   = 4'($urandom);
    load_regs(cfg);
    random_phase(300);

    // a timeout of all ones never ends the frame
    no_gaps = 1'b1;
    cfg.timeout = TICK_MAX;
    load_regs(cfg);
    push_req(OP_BYTE, BYTE_T);
    repeat (20) push_req(OP_TICK, 8'hFF);
    close_frame();
    no_gaps = 1'b0;
    drain();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    for (int n = 0; n < 20000 && expected_frames.size() != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_frames.size() != 0) begin
      $error("%0d expected results never arrived", expected_frames.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcfr_pkg.sv
rtl/tcfr_in_if.sv
rtl/tcfr_out_if.sv
rtl/tcfr_deframer.sv
rtl/tcfr_checker.sv
rtl/thruster_command_frame_receiver.sv
sim/thruster_command_frame_receiver_tb.sv
